// ===== design/plcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_pkg: shared types and constants
// Widths, queue entry and result kinds for the curve statistics block.
// ----------------------------------------------------------------------------
package plcs_pkg;
  localparam int unsigned MaxPointsDefault = 65536;
  localparam int unsigned QueueDepth       = 2;
  localparam logic        KindCrossing     = 1'b0;
  localparam logic        KindSummary      = 1'b1;

  // one classified word from the front to the back
  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic               seg;      // a segment exists
    logic               crosses;  // segment crosses or touches the axis
    logic               axis;     // both ends zero
    logic               last;
    logic [15:0]        idx;
  } plcs_item_t;
endpackage

// ===== design/plcs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_fifo: short queue
// Register based first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
module plcs_fifo
  import plcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  plcs_item_t wdata_i,
  output logic       full_o,
  input  logic       pop_i,
  output plcs_item_t rdata_o,
  output logic       empty_o
);
  plcs_item_t mem_q [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QueueDepth):0]   cnt_q;

  assign full_o  = (cnt_q == ($clog2(QueueDepth)+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 1'b1;
      if (pop_i && !empty_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + ((push_i && !full_o) ? 1'b1 : 1'b0)
                     - ((pop_i && !empty_o) ? 1'b1 : 1'b0);
    end
  end
endmodule

// ===== design/plcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_front: point intake
// Accepts points, pairs them with the previous one and classifies segments.
// ----------------------------------------------------------------------------
module plcs_front
  import plcs_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic               final_point_i,
  output logic               push_o,
  output plcs_item_t         item_o,
  input  logic               full_i
);
  logic signed [31:0] px_q, py_q;
  logic               have_q;
  logic [15:0]        cnt_q;
  logic               acc;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;
  assign push_o     = acc;

  // classification
  always_comb begin
    item_o.x0      = px_q;
    item_o.y0      = py_q;
    item_o.x1      = point_x_i;
    item_o.y1      = point_y_i;
    item_o.seg     = have_q;
    item_o.crosses = have_q && (py_q == 0 || point_y_i == 0 ||
                                (py_q[31] != point_y_i[31]));
    item_o.axis    = (py_q == 0) && (point_y_i == 0);
    item_o.last    = final_point_i;
    item_o.idx     = cnt_q;
  end

  // previous point and index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; have_q <= 1'b0; cnt_q <= '0;
    end else if (acc) begin
      if (final_point_i) begin
        px_q <= '0; py_q <= '0; have_q <= 1'b0; cnt_q <= '0;
      end else begin
        px_q <= point_x_i; py_q <= point_y_i; have_q <= 1'b1;
        if (32'(cnt_q) < MAX_POINTS - 1) cnt_q <= cnt_q + 1'b1;
      end
    end
  end
endmodule

// ===== design/plcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_back: segment execution
// Area accumulation, extremes and crossing division, then result output.
// ----------------------------------------------------------------------------
module plcs_back
  import plcs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  plcs_item_t         item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic signed [31:0] crossing_x_o,
  output logic               on_axis_o,
  output logic signed [63:0] area_total_o,
  output logic [15:0]        max_position_o,
  output logic signed [31:0] max_ordinate_o,
  output logic [15:0]        min_position_o,
  output logic signed [31:0] min_ordinate_o,
  output logic               run_end_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_AREA, S_DIV, S_CROSS, S_SUM
  } state_e;

  state_e             state_q;
  plcs_item_t         it_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] hi_q, lo_q;
  logic [15:0]        hii_q, loi_q;
  logic [63:0]        prod_q;    // area product magnitude
  logic               neg_q;
  logic [63:0]        num_q;     // dividend, shifted out two bits a cycle
  logic [32:0]        den_q;
  logic [32:0]        rem_q;     // partial remainder
  logic [31:0]        qbits_q;
  logic [6:0]         step_q;
  logic               out_load;

  logic [32:0] dx, sy, dy, ady, adx, asy;
  logic [31:0] ay0;
  assign dx  = 33'(it_q.x1) - 33'(it_q.x0);
  assign sy  = 33'(it_q.y0) + 33'(it_q.y1);
  assign dy  = 33'(it_q.y1) - 33'(it_q.y0);
  assign adx = dx[32] ? -dx : dx;
  assign asy = sy[32] ? -sy : sy;
  assign ady = dy[32] ? -dy : dy;
  assign ay0 = it_q.y0[31] ? 32'(-it_q.y0) : 32'(it_q.y0);

  // area term and saturating sum
  logic signed [63:0] term;
  logic signed [64:0] sum65;
  logic signed [63:0] sat;
  assign term  = neg_q ? -$signed(prod_q >> 1) : $signed(prod_q >> 1);
  assign sum65 = 65'(acc_q) + 65'(term);
  assign sat   = (sum65[64] != sum65[63]) ?
                 (sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum65[63:0];

  // restoring divider, two bits a cycle
  logic [33:0] r1, r2;
  logic        b1, b2;
  always_comb begin
    r1 = {rem_q, num_q[63]};
    b1 = (r1 >= {1'b0, den_q});
    if (b1) r1 = r1 - {1'b0, den_q};
    r2 = {r1[32:0], num_q[62]};
    b2 = (r2 >= {1'b0, den_q});
    if (b2) r2 = r2 - {1'b0, den_q};
  end
  logic signed [31:0] cx;
  assign cx = it_q.x0 + (dx[32] ? -qbits_q : qbits_q);

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  // output register takes a new word when empty or being drained
  assign out_load = ((state_q == S_CROSS) || (state_q == S_SUM)) &&
                    (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_valid_o <= 1'b0; acc_q <= '0;
      hi_q <= '0; lo_q <= '0; hii_q <= '0; loi_q <= '0;
      it_q <= '0; prod_q <= '0; neg_q <= 1'b0; num_q <= '0; den_q <= '0;
      rem_q <= '0; step_q <= '0; qbits_q <= '0;
      result_kind_o <= 1'b0; crossing_x_o <= '0; on_axis_o <= 1'b0;
      area_total_o <= '0; max_position_o <= '0; max_ordinate_o <= '0;
      min_position_o <= '0; min_ordinate_o <= '0; run_end_o <= 1'b0;
    end else begin
      if (out_ready_i && !out_load) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (!empty_i) begin
          it_q <= item_i;
          state_q <= S_MUL;
          if (!item_i.seg) begin
            hi_q <= item_i.y1; hii_q <= item_i.idx;
            lo_q <= item_i.y1; loi_q <= item_i.idx;
          end else begin
            if (item_i.y1 > hi_q) begin hi_q <= item_i.y1; hii_q <= item_i.idx; end
            if (item_i.y1 < lo_q) begin lo_q <= item_i.y1; loi_q <= item_i.idx; end
          end
        end
        // magnitude products for area (33-bit operands) and dividend (32x32)
        S_MUL: begin
          prod_q <= 64'(asy[31:0]) * 64'(adx[31:0])
                    + (asy[32] ? {adx[31:0], 32'd0} : 64'd0)
                    + (adx[32] ? {asy[31:0], 32'd0} : 64'd0);
          neg_q  <= sy[32] != dx[32];
          num_q  <= 64'(ay0) * 64'(adx[31:0]);
          den_q  <= ady;
          state_q <= S_AREA;
        end
        S_AREA: begin
          if (it_q.seg) acc_q <= sat;
          rem_q <= '0; qbits_q <= '0; step_q <= '0;
          if (it_q.crosses && !it_q.axis) state_q <= S_DIV;
          else if (it_q.crosses) state_q <= S_CROSS;
          else state_q <= it_q.last ? S_SUM : S_IDLE;
        end
        S_DIV: begin
          rem_q   <= r2[32:0];
          num_q   <= {num_q[61:0], 2'b00};
          qbits_q <= {qbits_q[29:0], b1, b2};
          step_q  <= step_q + 7'd2;
          if (step_q == 7'd62) state_q <= S_CROSS;
        end
        S_CROSS: if (out_load) begin
          out_valid_o <= 1'b1; result_kind_o <= KindCrossing;
          crossing_x_o <= it_q.axis ? it_q.x0 : cx; on_axis_o <= it_q.axis;
          area_total_o <= '0; max_position_o <= '0; max_ordinate_o <= '0;
          min_position_o <= '0; min_ordinate_o <= '0;
          run_end_o <= !it_q.last;
          state_q <= it_q.last ? S_SUM : S_IDLE;
        end
        S_SUM: if (out_load) begin
          out_valid_o <= 1'b1; result_kind_o <= KindSummary;
          crossing_x_o <= '0; on_axis_o <= 1'b0; area_total_o <= acc_q;
          max_position_o <= hii_q; max_ordinate_o <= hi_q;
          min_position_o <= loi_q; min_ordinate_o <= lo_q; run_end_o <= 1'b1;
          acc_q <= '0; hi_q <= '0; lo_q <= '0; hii_q <= '0; loi_q <= '0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/piecewise_linear_curve_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_curve_stats: curve statistics top level
// Zero crossings, trapezoidal area and extremes of a piecewise-linear curve.
// Each point goes through the queue, then the back end's idle, multiply and
// area states; a crossing adds the radix-4 divide unless on the axis, then a
// crossing word, and a final point a summary word. Points are taken while the
// queue has room; the back end works one point at a time; output stalls hold it.
// Reset: asynchronous active low, clears all curve state and the queue.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_stats
  import plcs_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic               final_point_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic signed [31:0] crossing_x_o,
  output logic               on_axis_o,
  output logic signed [63:0] area_total_o,
  output logic [15:0]        max_position_o,
  output logic signed [31:0] max_ordinate_o,
  output logic [15:0]        min_position_o,
  output logic signed [31:0] min_ordinate_o,
  output logic               run_end_o
);
  plcs_item_t wi, ri;
  logic push, full, pop, empty;

  plcs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .point_x_i, .point_y_i,
    .final_point_i, .push_o(push), .item_o(wi), .full_i(full));

  plcs_fifo u_fifo (.clk_i, .rst_ni, .push_i(push), .wdata_i(wi), .full_o(full),
    .pop_i(pop), .rdata_o(ri), .empty_o(empty));

  plcs_back u_back (.clk_i, .rst_ni, .empty_i(empty), .item_i(ri), .pop_o(pop),
    .out_valid_o, .out_ready_i, .result_kind_o, .crossing_x_o, .on_axis_o,
    .area_total_o, .max_position_o, .max_ordinate_o, .min_position_o,
    .min_ordinate_o, .run_end_o);
endmodule

// ===== design/plcs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_checker: port assertions
// Checks result framing as seen at the top level's ports.
// ----------------------------------------------------------------------------
module plcs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic result_kind_o,
  input logic on_axis_o,
  input logic run_end_o
);
  // a summary always ends its run
  a_sum_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> run_end_o) else $error("summary without run end");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o))
    else $error("result dropped");
  // on-axis flag only on crossings
  a_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && on_axis_o |-> !result_kind_o) else $error("axis flag on summary");
endmodule

bind piecewise_linear_curve_stats plcs_checker u_chk (.clk_i, .rst_ni, .out_valid_o,
  .out_ready_i, .result_kind_o, .on_axis_o, .run_end_o);

// ===== bench/tb_piecewise_linear_curve_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_curve_stats: self-checking bench for the curve block
// Streams curves of points into the block and predicts every crossing and
// summary word, comparing each output word field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_curve_stats;
  import plcs_pkg::*;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] cx;
    logic               axis;
    logic signed [63:0] area;
    logic [15:0]        maxp;
    logic signed [31:0] maxv;
    logic [15:0]        minp;
    logic signed [31:0] minv;
    logic               rend;
  } curve_word_t;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned LongStall  = 300;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] point_x_i;
  logic signed [31:0] point_y_i;
  logic               final_point_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               result_kind_o;
  logic signed [31:0] crossing_x_o;
  logic               on_axis_o;
  logic signed [63:0] area_total_o;
  logic [15:0]        max_position_o;
  logic signed [31:0] max_ordinate_o;
  logic [15:0]        min_position_o;
  logic signed [31:0] min_ordinate_o;
  logic               run_end_o;

  piecewise_linear_curve_stats dut (.*);

  // predictor state
  logic signed [31:0] last_x, last_y;
  logic               seen_point;
  logic signed [63:0] area_acc;
  logic signed [31:0] top_val, bot_val;
  logic [15:0]        top_idx, bot_idx;
  logic [16:0]        pt_count;

  curve_word_t expected_words[$];
  int          fail_count = 0;
  int          send_idle_pct, recv_idle_pct;
  logic        long_hold;
  event        stall_ev;
  int unsigned quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic clear_curve();
    last_x = '0; last_y = '0; seen_point = 1'b0; area_acc = '0;
    top_val = '0; bot_val = '0; top_idx = '0; bot_idx = '0; pt_count = '0;
  endtask

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // work out the words one point causes
  task automatic predict_point(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic fin);
    logic signed [63:0] dx, sy, term, sum;
    logic [63:0]        m, num, den, q;
    logic signed [63:0] cx;
    logic [15:0]        idx;
    curve_word_t        w;
    bit                 crossed;
    idx = pt_count[15:0];
    crossed = 0;
    if (seen_point) begin
      dx = 64'(x) - 64'(last_x);
      sy = 64'(last_y) + 64'(y);
      m = mag(sy) * mag(dx);
      term = $signed(m >> 1);
      if ((sy < 0) != (dx < 0)) term = -term;
      sum = area_acc + term;
      // saturate on signed overflow
      if (term > 0 && area_acc > 0 && sum < 0) sum = 64'h7fff_ffff_ffff_ffff;
      else if (term < 0 && area_acc < 0 && sum >= 0) sum = 64'h8000_0000_0000_0000;
      area_acc = sum;
      if (last_y == 0 || y == 0 || ((last_y < 0) != (y < 0))) begin
        w = '0;
        w.kind = KindCrossing;
        w.rend = 1'b1;
        if (last_y == 0 && y == 0) begin
          w.cx = last_x; w.axis = 1'b1;
        end else begin
          num = mag(64'(last_y)) * mag(dx);
          den = mag(64'(y) - 64'(last_y));
          q = num / den;
          cx = 64'(last_x) + (dx < 0 ? -$signed(q) : $signed(q));
          w.cx = cx[31:0];
        end
        expected_words = {expected_words, w};
        crossed = 1;
      end
      if (y > top_val) begin top_val = y; top_idx = idx; end
      if (y < bot_val) begin bot_val = y; bot_idx = idx; end
    end else begin
      top_val = y; bot_val = y; top_idx = idx; bot_idx = idx;
    end
    last_x = x; last_y = y; seen_point = 1'b1;
    if (pt_count < 17'd65535) pt_count++;
    if (fin) begin
      if (crossed) expected_words[$].rend = 1'b0;
      w = '0;
      w.kind = KindSummary;
      w.area = area_acc;
      w.maxp = top_idx; w.maxv = top_val;
      w.minp = bot_idx; w.minv = bot_val;
      w.rend = 1'b1;
      expected_words = {expected_words, w};
      clear_curve();
    end
  endtask

  // offer one point and wait for the handshake
  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    point_x_i     <= x;
    point_y_i     <= y;
    final_point_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_point(x, y, fin);
  endtask

  // long receiver stall, counted here
  initial begin
    long_hold = 1'b0;
    forever begin
      @(stall_ev);
      long_hold <= 1'b1;
      repeat (LongStall) @(posedge clk_i);
      long_hold <= 1'b0;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (long_hold) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each output word with the oldest prediction
  always @(posedge clk_i) begin
    curve_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind %0d", $time, result_kind_o);
        fail_count++;
      end else begin
        e = expected_words.pop_front();
        if (result_kind_o !== e.kind || crossing_x_o !== e.cx || on_axis_o !== e.axis
            || area_total_o !== e.area || max_position_o !== e.maxp
            || max_ordinate_o !== e.maxv || min_position_o !== e.minp
            || min_ordinate_o !== e.minv || run_end_o !== e.rend) begin
          $display("%0t: mismatch expected k%0d cx=%0d ax%0d a=%0d mx%0d@%0d mn%0d@%0d e%0d",
                   $time, e.kind, e.cx, e.axis, e.area, e.maxv, e.maxp, e.minv, e.minp,
                   e.rend);
          $display("%0t:          actual k%0d cx=%0d ax%0d a=%0d mx%0d@%0d mn%0d@%0d e%0d",
                   $time, result_kind_o, crossing_x_o, on_axis_o, area_total_o,
                   max_ordinate_o, max_position_o, min_ordinate_o, min_position_o,
                   run_end_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni) quiet_cycles <= 0;
    else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("tb_piecewise_linear_curve_stats: FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return $signed(32'($urandom_range(200000))) - 100000;
      default: return $signed($urandom());
    endcase
  endfunction

  // one random curve of n points, x mostly increasing, at times a random x
  task automatic send_curve(input int n);
    logic signed [63:0] x;
    logic signed [31:0] y;
    x = -64'sd2147483648 + $urandom_range(1000);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(4))
        0:       y = '0;
        1:       y = $signed(32'($urandom_range(16))) - 8;
        default: y = rand_word();
      endcase
      if ($urandom_range(19) == 0) send_point(rand_word(), y, i == n - 1);
      else send_point(x[31:0], y, i == n - 1);
      x = x + 1 + ($urandom_range(3) == 0 ? $urandom() % 32'h0100_0000 : $urandom_range(70000));
      if (x > 64'sh7fff_ffff) x = 64'sh7fff_ffff;
    end
  endtask

  task automatic test_directed();
    // single point curve
    send_point(32'sd5, -32'sd3, 1'b1);
    // extremes of both fields, sign change through full range
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    // both ends zero, touching zero, equal extremes
    send_point(-32'sd10, 32'sd0, 1'b0);
    send_point(32'sd10, 32'sd0, 1'b0);
    send_point(32'sd20, 32'sd7, 1'b0);
    send_point(32'sd30, 32'sd7, 1'b0);
    send_point(32'sd40, -32'sd7, 1'b0);
    send_point(32'sd50, -32'sd7, 1'b1);
    // x not increasing
    send_point(32'sd100, 32'sd4, 1'b0);
    send_point(32'sd50, -32'sd6, 1'b0);
    send_point(32'sd50, 32'sd9, 1'b1);
    // area saturation upward
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    // area saturation downward
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
  endtask

  task automatic test_random(input int points);
    int sent, n;
    sent = 0;
    while (sent < points) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 8);
      send_curve(n);
      sent += n;
    end
  endtask

  task automatic test_backpressure();
    -> stall_ev;
    send_curve(40);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    send_idle_pct = 7; recv_idle_pct = 49;
    in_valid_i = 1'b0; point_x_i = '0; point_y_i = '0; final_point_i = 1'b0;
    clear_curve();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(400);
    test_backpressure();
    send_idle_pct = 49; recv_idle_pct = 7;
    test_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400);
    drain();

    if (fail_count == 0) $display("tb_piecewise_linear_curve_stats: PASS");
    else $display("tb_piecewise_linear_curve_stats: FAIL");
    $finish;
  end
endmodule
